// ===== design/tbhd_pkg.sv =====
package tbhd_pkg;

    // Fixed-point scale of the angle path (Q16 degrees) and the coordinate pre-shift.
    localparam int PRE_SHIFT = 20;
    localparam int ZW        = 26;
    localparam int TAB_LEN   = 24;

    // Arctangent of 2^-i in Q16 degrees, rounded.
    localparam logic [21:0] ATAN_Q16 [TAB_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    localparam logic [22:0] DEG90_Q16  = 23'd5898240;
    localparam logic [24:0] DEG180_Q16 = 25'd11796480;

    // Per-word control carried alongside the data through the cell row.
    typedef struct packed {
        logic       valid;
        logic       same_pt;
        logic       ay_zero;
        logic       ax_zero;
        logic       diag;
        logic       dx_pos;
        logic       dx_neg;
        logic       dy_neg;
        logic [8:0] head;
    } tbhd_ctl_t;

endpackage

// ===== design/tbhd_if.sv =====
interface tbhd_in_if;
    logic       valid;
    logic       ready;
    logic [8:0] robot_x;
    logic [8:0] robot_y;
    logic [8:0] goal_x;
    logic [8:0] goal_y;
    logic [8:0] heading_deg;

    modport source (output valid, robot_x, robot_y, goal_x, goal_y, heading_deg,
                    input ready);
    modport sink   (input valid, robot_x, robot_y, goal_x, goal_y, heading_deg,
                    output ready);
endinterface

interface tbhd_out_if;
    logic              valid;
    logic              ready;
    logic [8:0]        bearing_deg;
    logic signed [8:0] turn_deg;
    logic [9:0]        distance;

    modport source (output valid, bearing_deg, turn_deg, distance, input ready);
    modport sink   (input valid, bearing_deg, turn_deg, distance, output ready);
endinterface

// ===== design/tbhd_cell.sv =====
module tbhd_cell #(
    parameter int W         = 32,
    parameter int SB        = 10,
    parameter int STAGE     = 0,
    parameter bit DO_CORDIC = 1'b1,
    parameter bit DO_SQRT   = 1'b1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  tbhd_pkg::tbhd_ctl_t       ctl_in,
    input  logic signed [W-1:0]       x_in,
    input  logic signed [W-1:0]       y_in,
    input  logic signed [tbhd_pkg::ZW-1:0] z_in,
    input  logic [2*SB-1:0]           n_in,
    input  logic [SB+1:0]             rem_in,
    input  logic [SB-1:0]             r_in,
    output tbhd_pkg::tbhd_ctl_t       ctl_out,
    output logic signed [W-1:0]       x_out,
    output logic signed [W-1:0]       y_out,
    output logic signed [tbhd_pkg::ZW-1:0] z_out,
    output logic [2*SB-1:0]           n_out,
    output logic [SB+1:0]             rem_out,
    output logic [SB-1:0]             r_out
);
    import tbhd_pkg::*;

    localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_Q16[STAGE]);

    tbhd_ctl_t             ctl_reg;
    logic signed [W-1:0]   x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic [2*SB-1:0]       n_reg, n_next;
    logic [SB+1:0]         rem_reg, rem_next, rem_t, trial;
    logic [SB-1:0]         r_reg, r_next;

    // one CORDIC rotation toward y = 0
    always_comb
    begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        if (!DO_CORDIC)
        begin
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
        end
        else if (!y_in[W-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_I;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_I;
        end
    end

    // one digit of the restoring square root
    always_comb
    begin
        rem_t = {rem_in[SB-1:0], n_in[2*SB-1 -: 2]};
        trial = {r_in, 2'b01};
        if (!DO_SQRT)
        begin
            rem_next = rem_in;
            r_next   = r_in;
            n_next   = n_in;
        end
        else
        begin
            n_next = n_in << 2;
            if (rem_t >= trial)
            begin
                rem_next = rem_t - trial;
                r_next   = {r_in[SB-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_t;
                r_next   = {r_in[SB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            n_reg   <= n_next;
            rem_reg <= rem_next;
            r_reg   <= r_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign n_out   = n_reg;
    assign rem_out = rem_reg;
    assign r_out   = r_reg;

endmodule

// ===== design/target_bearing_heading_distance.sv =====
// Channel | Dir | Word
// query   | in  | robot_x, robot_y, goal_x, goal_y, heading_deg
// result  | out | bearing_deg, turn_deg, distance
//
// One word per cycle unless a result is stalled. A word passes a prep register (deltas,
// squares), the cell row, and the output register. Each cell does at most one CORDIC
// rotation and one square-root digit; the row length, max(CORDIC_STAGES, COORD_BITS+1),
// sets the latency. Reset clears all valid flags; no clearing pass.
// The whole pipe advances together whenever the output register is empty or being
// taken, so query.ready falls only while a result sits stalled.
module target_bearing_heading_distance #(
    parameter int COORD_BITS    = 9,
    parameter int CORDIC_STAGES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    tbhd_in_if.sink   query,
    tbhd_out_if.source result
);
    import tbhd_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int W  = C + PRE_SHIFT + 3;        // CORDIC gain and sign headroom
    localparam int SB = C + 1;                    // root digits
    localparam int NC = (CORDIC_STAGES > SB) ? CORDIC_STAGES : SB;

    logic en;

    // ---------------- prep stage ----------------
    logic [C-1:0]          rx, ry, gx, gy, ax, ay;
    logic signed [C:0]     dx, dy;
    logic [2*C-1:0]        sqx, sqy;
    tbhd_ctl_t             pctl;

    tbhd_ctl_t             prep_ctl_reg;
    logic [C-1:0]          ax_reg, ay_reg;
    logic [2*C:0]          nsum_reg;

    always_comb
    begin
        // coordinates keep their low C bits, zero-extended when C is wider than the port
        rx = C'(query.robot_x);
        ry = C'(query.robot_y);
        gx = C'(query.goal_x);
        gy = C'(query.goal_y);
        dx = $signed({1'b0, rx}) - $signed({1'b0, gx});
        dy = $signed({1'b0, ry}) - $signed({1'b0, gy});
        ax = dx[C] ? C'(-dx) : dx[C-1:0];
        ay = dy[C] ? C'(-dy) : dy[C-1:0];
        sqx = ax * ax;
        sqy = ay * ay;
        pctl.valid   = query.valid;
        pctl.same_pt = (dx == '0) && (dy == '0);
        pctl.ay_zero = (ay == '0);
        pctl.ax_zero = (ax == '0);
        pctl.diag    = (ax == ay);
        pctl.dx_pos  = !dx[C] && (dx != '0);
        pctl.dx_neg  = dx[C];
        pctl.dy_neg  = dy[C];
        pctl.head    = query.heading_deg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_ctl_reg <= '0;
        end
        else if (en)
        begin
            prep_ctl_reg <= pctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg   <= ax;
            ay_reg   <= ay;
            nsum_reg <= {1'b0, sqx} + {1'b0, sqy};
        end
    end

    // ---------------- cell row ----------------
    tbhd_ctl_t             ctl_c [NC+1];
    logic signed [W-1:0]   x_c   [NC+1];
    logic signed [W-1:0]   y_c   [NC+1];
    logic signed [ZW-1:0]  z_c   [NC+1];
    logic [2*SB-1:0]       n_c   [NC+1];
    logic [SB+1:0]         rem_c [NC+1];
    logic [SB-1:0]         r_c   [NC+1];

    assign ctl_c[0] = prep_ctl_reg;
    assign x_c[0]   = $signed(W'({ax_reg, {PRE_SHIFT{1'b0}}}));
    assign y_c[0]   = $signed(W'({ay_reg, {PRE_SHIFT{1'b0}}}));
    assign z_c[0]   = '0;
    assign n_c[0]   = {1'b0, nsum_reg};
    assign rem_c[0] = '0;
    assign r_c[0]   = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        tbhd_cell #(
            .W         (W),
            .SB        (SB),
            .STAGE     (i),
            .DO_CORDIC (i < CORDIC_STAGES),
            .DO_SQRT   (i < SB)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_c[i]),
            .x_in    (x_c[i]),
            .y_in    (y_c[i]),
            .z_in    (z_c[i]),
            .n_in    (n_c[i]),
            .rem_in  (rem_c[i]),
            .r_in    (r_c[i]),
            .ctl_out (ctl_c[i+1]),
            .x_out   (x_c[i+1]),
            .y_out   (y_c[i+1]),
            .z_out   (z_c[i+1]),
            .n_out   (n_c[i+1]),
            .rem_out (rem_c[i+1]),
            .r_out   (r_c[i+1])
        );
    end

    // ---------------- finish: clamp, quadrant, fold ----------------
    tbhd_ctl_t             fctl;
    logic signed [ZW-1:0]  zf, theta, a;
    logic [ZW-1:0]         ub;
    logic [8:0]            v;
    logic signed [10:0]    d, dfold;

    logic                  out_valid_reg;
    logic [8:0]            bearing_reg;
    logic signed [8:0]     turn_reg;
    logic [9:0]            dist_reg;

    always_comb
    begin
        fctl = ctl_c[NC];
        zf   = z_c[NC];
        if (fctl.ay_zero)
            theta = '0;
        else if (fctl.ax_zero)
            theta = ZW'(DEG90_Q16);
        else if (fctl.diag)
            theta = ZW'(DEG90_Q16 >> 1);
        else if (zf < 0)
            theta = '0;
        else if (zf > $signed(ZW'(DEG90_Q16)))
            theta = ZW'(DEG90_Q16);
        else
            theta = zf;

        if (fctl.same_pt)
            a = '0;
        else if (!fctl.dy_neg)
            a = fctl.dx_pos ? theta : $signed(ZW'(DEG180_Q16)) - theta;
        else
            a = fctl.dx_neg ? theta - $signed(ZW'(DEG180_Q16)) : -theta;

        ub = ZW'(a + $signed(ZW'(DEG180_Q16)));
        v  = ub[24:16];
        d  = $signed({2'b00, v}) - $signed({2'b00, fctl.head});
        if (d > 11'sd180)
            dfold = d - 11'sd360;
        else if (d < -11'sd180)
            dfold = d + 11'sd360;
        else
            dfold = d;
    end

    assign en = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bearing_reg <= (v == 9'd360) ? 9'd0 : v;
            turn_reg    <= dfold[8:0];
            dist_reg    <= 10'(r_c[NC]);
        end
    end

    assign query.ready        = en;
    assign result.valid       = out_valid_reg;
    assign result.bearing_deg = bearing_reg;
    assign result.turn_deg    = turn_reg;
    assign result.distance    = dist_reg;

    // ---------------- checks ----------------
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> bearing_reg < 9'd360)
        else $error("bearing out of range");

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (turn_reg >= -9'sd180) && (turn_reg <= 9'sd180))
        else $error("turn out of range");

    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (COORD_BITS <= 9) && out_valid_reg && (dist_reg == 10'd0)
            |-> bearing_reg == 9'd180)
        else $error("coincident points must give bearing 180");

    a_pipe_move: assert property (@(posedge clk) disable iff (!rst_n)
        en && fctl.valid |=> out_valid_reg)
        else $error("word lost at output register");

endmodule
